### rtl/modular_exponentiation_assert.svh
// Assertion macros shared by the exponentiation block
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/me_pkg.sv
`default_nettype none
package me_pkg;

  localparam int VALUE_WIDTH_DEF    = 32;
  localparam int EXPONENT_WIDTH_DEF = 64;
  localparam logic [63:0] MODULUS_RESET = 64'd998244353;

  localparam logic [1:0] OP_REDUCE = 2'd0;
  localparam logic [1:0] OP_MUL    = 2'd1;
  localparam logic [1:0] OP_SQR    = 2'd2;

  typedef struct packed {
    logic       load;
    logic       start;
    logic [1:0] op;
    logic       shift;
    logic       emit;
  } me_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_last;
    logic exp_bit0;
    logic busy;
    logic mul_done;
    logic out_stall;
  } me_status_t;

endpackage
`default_nettype wire

### rtl/me_in_if.sv
`default_nettype none
interface me_in_if #(
  parameter int VALUE_WIDTH    = 32,
  parameter int EXPONENT_WIDTH = 64
);
  logic                      valid;
  logic                      ready;
  logic [VALUE_WIDTH-1:0]    base;
  logic [EXPONENT_WIDTH-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink (input valid, input base, input exponent, output ready);
endinterface
`default_nettype wire

### rtl/me_out_if.sv
`default_nettype none
interface me_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink (input valid, input power_mod, output ready);
endinterface
`default_nettype wire

### rtl/me_cfg_if.sv
`default_nettype none
interface me_cfg_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink (input valid, input modulus, output ready);
endinterface
`default_nettype wire

### rtl/me_datapath.sv
`default_nettype none
module me_datapath
  import me_pkg::*;
#(
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int EXPONENT_WIDTH = EXPONENT_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire me_cmd_t                   cmd,
  output me_status_t                     st,
  input  wire logic [VALUE_WIDTH-1:0]    base,
  input  wire logic [EXPONENT_WIDTH-1:0] exponent,
  input  wire logic                      cfg_we,
  input  wire logic [VALUE_WIDTH-1:0]    cfg_modulus,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [VALUE_WIDTH-1:0]         power_mod
);

  logic [VALUE_WIDTH-1:0]    modulus;
  logic [VALUE_WIDTH-1:0]    acc;
  logic [VALUE_WIDTH-1:0]    power;
  logic [EXPONENT_WIDTH-1:0] expo;
  logic [VALUE_WIDTH-1:0]    mx;
  logic [VALUE_WIDTH-1:0]    my;
  logic [VALUE_WIDTH-1:0]    mp;
  logic                      busy;
  logic [1:0]                op_r;
  logic [VALUE_WIDTH-1:0]    one_mod;
  logic                      mul_done;

  function automatic logic [VALUE_WIDTH-1:0] add_mod(
    input logic [VALUE_WIDTH-1:0] a,
    input logic [VALUE_WIDTH-1:0] b,
    input logic [VALUE_WIDTH-1:0] m
  );
    logic [VALUE_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if ((m != '0) && (s >= {1'b0, m})) begin
      s = s - {1'b0, m};
    end
    return s[VALUE_WIDTH-1:0];
  endfunction

  assign one_mod  = (modulus == VALUE_WIDTH'(1)) ? '0 : VALUE_WIDTH'(1);
  assign mul_done = busy && (my == '0);

  always_comb begin
    st.exp_zero  = (expo == '0);
    st.exp_last  = (expo[EXPONENT_WIDTH-1:1] == '0);
    st.exp_bit0  = expo[0];
    st.busy      = busy;
    st.mul_done  = mul_done;
    st.out_stall = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= MODULUS_RESET[VALUE_WIDTH-1:0];
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        modulus <= cfg_modulus;
      end
      if (cmd.load) begin
        acc   <= (exponent == '0) ? VALUE_WIDTH'(1) : one_mod;
        power <= base;
        expo  <= exponent;
      end
      if (busy) begin
        if (my == '0) begin
          busy <= 1'b0;
          case (op_r)
            OP_MUL:  acc <= mp;
            default: power <= mp;
          endcase
        end else begin
          if (my[0]) begin
            mp <= add_mod(mp, mx, modulus);
          end
          mx <= add_mod(mx, mx, modulus);
          my <= my >> 1;
        end
      end
      if (cmd.start) begin
        busy <= 1'b1;
        mp   <= '0;
        op_r <= cmd.op;
        case (cmd.op)
          OP_REDUCE: begin
            mx <= one_mod;
            my <= power;
          end
          OP_MUL: begin
            mx <= acc;
            my <= power;
          end
          default: begin
            mx <= power;
            my <= power;
          end
        endcase
      end
      if (cmd.shift) begin
        expo <= expo >> 1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        power_mod <= acc;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/me_controller.sv
`default_nettype none
module me_controller
  import me_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire me_status_t st,
  output me_cmd_t         cmd
);

  `include "modular_exponentiation_assert.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_REDST = 3'd1;
  localparam logic [2:0] S_RED   = 3'd2;
  localparam logic [2:0] S_NEXT  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_SQR   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_REDUCE;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_REDST;
        end
      end
      S_REDST: begin
        if (st.exp_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = OP_REDUCE;
          state_next = S_RED;
        end
      end
      S_RED: begin
        if (st.mul_done) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (st.exp_zero) begin
          state_next = S_FIN;
        end else if (st.exp_bit0) begin
          cmd.start  = 1'b1;
          cmd.op     = OP_MUL;
          state_next = S_MUL;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = OP_SQR;
          state_next = S_SQR;
        end
      end
      S_MUL: begin
        if (st.mul_done) begin
          if (st.exp_last) begin
            state_next = S_FIN;
          end else begin
            cmd.start  = 1'b1;
            cmd.op     = OP_SQR;
            state_next = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (st.mul_done) begin
          cmd.shift  = 1'b1;
          state_next = S_NEXT;
        end
      end
      S_FIN: begin
        if (!st.out_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ME_ASSERT_NOW(a_start_free, cmd.start, !st.busy || st.mul_done, "multiplier started while busy")
  `ME_ASSERT_NOW(a_emit_free, cmd.emit, !st.out_stall, "result overwritten while held")
  `ME_ASSERT_NOW(a_done_state, st.mul_done, state == S_RED || state == S_MUL || state == S_SQR, "multiply finished outside a multiply state")
  `ME_ASSERT_NEXT(a_load_then, cmd.load, state == S_REDST && !st.busy, "load not followed by setup")

endmodule
`default_nettype wire

### rtl/modular_exponentiation.sv
// Run time is data dependent: it follows the exponent bits and the multiplier operands.
// Each modular multiply runs on one shared bit-serial add-and-double unit, one bit per cycle.
// Items are taken one at a time, only while idle; the next beat is taken while a result waits.
// Zero exponent: no multiply runs; the controller goes from S_REDST straight to S_FIN and emits the result.
// Reset (rst, synchronous, active high): modulus returns to 998244353, no item held.
`default_nettype none
module modular_exponentiation
  import me_pkg::*;
#(
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int EXPONENT_WIDTH = EXPONENT_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  me_in_if.sink    request,
  me_out_if.source result,
  me_cfg_if.sink   cfg
);

  me_cmd_t    cmd;
  me_status_t st;

  assign cfg.ready = 1'b1;

  me_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .st       (st),
    .cmd      (cmd)
  );

  me_datapath #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .EXPONENT_WIDTH (EXPONENT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .base        (request.base),
    .exponent    (request.exponent),
    .cfg_we      (cfg.valid),
    .cfg_modulus (cfg.modulus),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .power_mod   (result.power_mod)
  );

endmodule
`default_nettype wire

### tb/sv/modular_exponentiation_tb.sv
typedef logic [me_pkg::VALUE_WIDTH_DEF-1:0]    value_t;
typedef logic [me_pkg::EXPONENT_WIDTH_DEF-1:0] expo_t;

class power_mod_board;
  value_t      modulus;
  value_t      power_mod_due[$];
  int unsigned mismatches;

  function new();
    modulus    = value_t'(me_pkg::MODULUS_RESET);
    mismatches = 0;
  endfunction

  static function value_t mul_reduce(value_t x, value_t y, value_t m);
    logic [63:0] prod;
    prod = 64'(x) * 64'(y);
    if (m == '0) return prod[me_pkg::VALUE_WIDTH_DEF-1:0];
    return value_t'(prod % 64'(m));
  endfunction

  function void note_request(value_t b, expo_t e);
    value_t acc;
    value_t pw;
    acc = value_t'(1);
    pw  = b;
    if (e != '0) begin
      if (modulus != '0) begin
        pw  = b % modulus;
        acc = value_t'(1) % modulus;
      end
      for (int i = 0; i < me_pkg::EXPONENT_WIDTH_DEF; i++) begin
        if (e[i]) acc = mul_reduce(acc, pw, modulus);
        pw = mul_reduce(pw, pw, modulus);
      end
    end
    power_mod_due.push_back(acc);
  endfunction

  function void check_result(value_t got);
    value_t want;
    if (power_mod_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected power_mod beat: got %h", got);
      return;
    end
    want = power_mod_due.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("power_mod mismatch: expected %h, got %h", want, got);
    end
  endfunction

  function int pending();
    return power_mod_due.size();
  endfunction
endclass

module modular_exponentiation_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import me_pkg::*;

  localparam int VW          = VALUE_WIDTH_DEF;
  localparam int EW          = EXPONENT_WIDTH_DEF;
  localparam int ITEM_CYCLES = EW * (2 * VW + 3) + 2;
  localparam int CYCLE_LIMIT = 200 * ITEM_CYCLES * 3;
  localparam int RAND_PHASES = 7;
  localparam int PHASE_ITEMS = 17;

  logic clk = 1'b0;
  logic rst;
  logic steady;
  int unsigned cycles;
  power_mod_board board;

  me_in_if  #(.VALUE_WIDTH(VW), .EXPONENT_WIDTH(EW)) request_bus ();
  me_out_if #(.VALUE_WIDTH(VW))                      result_bus ();
  me_cfg_if #(.VALUE_WIDTH(VW))                      cfg_bus ();

  modular_exponentiation #(.VALUE_WIDTH(VW), .EXPONENT_WIDTH(EW)) dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_bus),
    .result  (result_bus),
    .cfg     (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_item(input value_t b, input expo_t e);
    while (!steady && $urandom_range(99) < 11) begin
      request_bus.valid <= 1'b0;
      @(posedge clk);
    end
    request_bus.valid    <= 1'b1;
    request_bus.base     <= b;
    request_bus.exponent <= e;
    @(posedge clk);
    while (!request_bus.ready) @(posedge clk);
    board.note_request(b, e);
  endtask

  task automatic drain();
    request_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(input value_t v);
    cfg_bus.valid   <= 1'b1;
    cfg_bus.modulus <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    board.modulus = v;
  endtask

  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_bus.valid && result_bus.ready) board.check_result(result_bus.power_mod);
      result_bus.ready <= steady || ($urandom_range(99) >= 11);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    value_t m;
    value_t b;
    expo_t  e;
    board = new();
    steady = 1'b0;
    rst <= 1'b1;
    request_bus.valid    <= 1'b0;
    request_bus.base     <= '0;
    request_bus.exponent <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.modulus      <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_item('0, '0);
    send_item('1, '0);
    send_item(value_t'(2), expo_t'(1));
    send_item('1, '1);
    send_item(value_t'(998244353), expo_t'(5));
    send_item(value_t'(998244354), expo_t'(3));
    send_item('0, expo_t'(5));
    send_item(value_t'(3), expo_t'(998244351));
    send_item(value_t'(12345), 64'h8000_0000_0000_0000);

    drain();
    write_modulus(value_t'(1));
    send_item(value_t'(5), '0);
    send_item(value_t'(5), expo_t'(1));
    send_item('1, '1);

    drain();
    write_modulus('0);
    send_item(value_t'(3), '1);
    send_item('1, expo_t'(2));
    send_item(value_t'(2), expo_t'(32));
    send_item('0, '0);

    drain();
    write_modulus('1);
    send_item('1, expo_t'(1));
    send_item(32'hFFFF_FFFE, '1);
    send_item(32'hFFFF_FFFE, expo_t'(2));

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case (p)
        0, 3:    m = $urandom;
        1:       m = $urandom_range(2, 300);
        2:       m = {1'b1, 31'($urandom)};
        4:       m = $urandom_range(1, 3);
        5:       m = $urandom_range(1) ? '0 : '1;
        default: m = value_t'(MODULUS_RESET);
      endcase
      write_modulus(m);
      steady = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(3))
          0:       b = $urandom;
          1:       b = $urandom_range(0, 15);
          2:       b = m + $urandom_range(0, 2) - 1;
          default: b = '1 - $urandom_range(0, 3);
        endcase
        case ($urandom_range(9))
          0:          e = '0;
          1:          e = $urandom_range(1, 3);
          2, 3, 4:    e = {$urandom, $urandom} >> $urandom_range(40, 63);
          9:          e = '1 - $urandom_range(0, 7);
          default:    e = {$urandom, $urandom};
        endcase
        send_item(b, e);
        if (n < PHASE_ITEMS - 1 && (n == 10 || $urandom_range(24) == 0)) drain();
      end
    end
    steady = 1'b0;

    drain();
    repeat (ITEM_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
